>>> hw/rtl/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

	// Default geometry of the palette and the shading rules.
	localparam int PALETTE_ENTRIES   = 256;
	localparam int HOUSE_RANGE_FIRST = 80;
	localparam int FADE_STEPS        = 16;
	localparam int HOUSE_SHADES      = 16;

	// Data widths.
	localparam int CHAN_W   = 8;
	localparam int RGB_W    = 3 * CHAN_W;
	localparam int DIST_W   = 18;
	localparam int SHADOW_W = 9;
	localparam int FACTOR_W = 9;

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Remap modes.
	localparam logic [2:0] MODE_DIRECT = 3'd0;
	localparam logic [2:0] MODE_HOUSE  = 3'd1;
	localparam logic [2:0] MODE_SHADOW = 3'd2;
	localparam logic [2:0] MODE_FADE   = 3'd3;
	localparam logic [2:0] MODE_GHOST  = 3'd4;

	// Shading constants.
	localparam logic [CHAN_W-1:0]   CHAN_MAX      = 8'hFF;
	localparam logic [SHADOW_W-1:0] SHADOW_FULL   = 9'd256;
	localparam logic [SHADOW_W-1:0] SHADOW_RESET  = 9'd128;
	localparam logic [FACTOR_W-1:0] HOUSE_BIAS    = 9'd45;
	localparam logic [FACTOR_W-1:0] HOUSE_STEP    = 9'd7;

	// Division by a constant is a multiply by a rounded-up reciprocal and a shift.
	localparam int                 RECIP_SHIFT  = 24;
	localparam int                 RECIP_W      = 25;
	localparam logic [RECIP_W-1:0] HOUSE_RECIP  = 25'd111849;
	localparam logic [RECIP_W-1:0] SHADOW_RECIP = 25'd65536;

	// Which scaling rule the shared multiply unit applies.
	typedef enum logic [1:0] {
		SCALE_HOUSE  = 2'd0,
		SCALE_SHADOW = 2'd1,
		SCALE_FADE   = 2'd2
	} scale_kind_t;

	// Palette memory controls from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic scan;
	} mem_ctl_t;

	// Fixed house base colors as {red, green, blue}.
	function automatic logic [RGB_W-1:0] house_base(input logic [2:0] sel);
		logic [RGB_W-1:0] rgb;
		unique case (sel)
			3'd0:    rgb = {8'd255, 8'd255, 8'd0};
			3'd1:    rgb = {8'd0,   8'd160, 8'd255};
			3'd2:    rgb = {8'd255, 8'd0,   8'd0};
			3'd3:    rgb = {8'd0,   8'd200, 8'd0};
			3'd4:    rgb = {8'd255, 8'd128, 8'd0};
			3'd5:    rgb = {8'd128, 8'd128, 8'd128};
			3'd6:    rgb = {8'd0,   8'd0,   8'd255};
			default: rgb = {8'd140, 8'd80,  8'd40};
		endcase
		return rgb;
	endfunction

endpackage

>>> hw/rtl/prc_req_if.sv
`timescale 1ns / 1ps

interface prc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] color_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [2:0] remap_mode;
	logic [3:0] fade_level;
	logic [2:0] house_color;

	modport source (
		output valid, req_type, color_index, red, green, blue,
		       remap_mode, fade_level, house_color,
		input  ready
	);

	modport sink (
		input  valid, req_type, color_index, red, green, blue,
		       remap_mode, fade_level, house_color,
		output ready
	);
endinterface

>>> hw/rtl/prc_rsp_if.sv
`timescale 1ns / 1ps

interface prc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] match_index;

	modport source (
		output valid, match_index,
		input  ready
	);

	modport sink (
		input  valid, match_index,
		output ready
	);
endinterface

>>> hw/rtl/palette_remap_nearest_color_unit.sv
`timescale 1ns / 1ps

// Nearest palette color remapper.
// Requests arrive on req (valid/ready). A write request loads one palette
// entry and gives no response. A query request derives a target color
// (direct, house shade, shadow, fade or ghost) and scans palette entries
// 1 to PALETTE_ENTRIES-1 for the least squared RGB distance; the lowest
// index wins ties. One response per query leaves on rsp.
// The scan reads one palette entry per cycle through a single distance
// pipeline. Shadow and fade queries first add a source read and a shared
// multiply unit that works one channel at a time; house shade queries add
// only the multiply and ghost queries only the source read.
// Queries that pass the index through go straight to the finish state.
// req.ready is high only while the sequencer is idle, so one query is in
// flight at a time and a direct query holds the block until it finishes.
// A finished response sits in an output register; while
// rsp stalls the block keeps taking write requests, and a following query
// waits for the register to empty before it completes.
// cfg_write loads the shadow intensity. Reset clears the sequencer, the
// output register and sets the intensity to 128; the palette contents are
// undefined until written and every entry must be loaded before a query.
module palette_remap_nearest_color_unit #(
	parameter int PALETTE_ENTRIES   = prc_pkg::PALETTE_ENTRIES,
	parameter int HOUSE_RANGE_FIRST = prc_pkg::HOUSE_RANGE_FIRST,
	parameter int FADE_STEPS        = prc_pkg::FADE_STEPS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	prc_req_if.sink                         req,
	prc_rsp_if.source                       rsp,
	input  logic                            cfg_write,
	input  logic [prc_pkg::SHADOW_W-1:0]    cfg_wdata
);

	localparam int AW       = $clog2(PALETTE_ENTRIES);
	localparam int CW       = prc_pkg::CHAN_W;
	localparam int RW       = prc_pkg::RGB_W;
	localparam int FADE_TOP = FADE_STEPS - 1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SRC_RD = 7'b0000010,
		ST_SRC    = 7'b0000100,
		ST_SCALE  = 7'b0001000,
		ST_SEARCH = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t                          state_q, state_d;
	logic [2:0]                      cnt_q;
	logic [AW-1:0]                   scan_q;
	logic                            out_vld_q;
	logic [7:0]                      out_idx_q;
	logic [prc_pkg::SHADOW_W-1:0]    shadow_q;

	logic [2:0]                      mode_q;
	logic [7:0]                      idx_q;
	logic [3:0]                      level_q;
	logic [2:0]                      house_q;
	logic [3:0]                      pos_q;
	logic                            src_ok_q;
	logic [RW-1:0]                   src_q;
	logic [RW-1:0]                   tgt_q;
	logic [7:0]                      res_q;

	logic                            accept;
	logic                            is_query;
	logic                            src_ok_in;
	logic                            house_hit;
	logic [8:0]                      idx_ext;
	logic                            out_load;

	prc_pkg::mem_ctl_t               ctl;
	logic [AW-1:0]                   rd_addr;
	logic [RW-1:0]                   rd_data;
	logic [RW-1:0]                   src_val;
	logic                            busy;
	logic [AW-1:0]                   near_idx;

	logic [CW-1:0]                   sc_operand;
	logic [prc_pkg::FACTOR_W-1:0]    sc_factor;
	prc_pkg::scale_kind_t            sc_kind;
	logic [CW-1:0]                   sc_result;
	logic [prc_pkg::SHADOW_W-1:0]    shadow_clamp;
	logic [3:0]                      level_clamp;

	function automatic logic [CW-1:0] chan_of(input logic [RW-1:0] rgb,
	                                          input logic [1:0] ch);
		logic [CW-1:0] c;
		case (ch)
			2'd0:    c = rgb[RW-1 -: CW];
			2'd1:    c = rgb[RW-1-CW -: CW];
			default: c = rgb[CW-1:0];
		endcase
		return c;
	endfunction

	function automatic logic [CW-1:0] ghost_of(input logic [CW-1:0] s);
		logic [CW:0] sum;
		sum = {1'b0, s} + {1'b0, prc_pkg::CHAN_MAX};
		return sum[CW:1];
	endfunction

	// Handshake and request decode.
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_query  = (req.req_type == prc_pkg::REQ_QUERY);
	assign idx_ext   = {1'b0, req.color_index};
	assign src_ok_in = idx_ext < 9'(PALETTE_ENTRIES);
	assign house_hit = (idx_ext >= 9'(HOUSE_RANGE_FIRST)) &&
	                   (idx_ext < 9'(HOUSE_RANGE_FIRST + prc_pkg::HOUSE_SHADES));
	assign out_load  = (state_q == ST_FINISH) && (!out_vld_q || rsp.ready);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					case (req.remap_mode) inside
						prc_pkg::MODE_DIRECT: state_d = ST_SEARCH;
						prc_pkg::MODE_HOUSE:  state_d = house_hit ? ST_SCALE : ST_FINISH;
						prc_pkg::MODE_SHADOW, prc_pkg::MODE_FADE, prc_pkg::MODE_GHOST:
							state_d = (req.color_index == 8'd0) ? ST_FINISH : ST_SRC_RD;
						default:              state_d = ST_FINISH;
					endcase
				end
			end
			ST_SRC_RD: state_d = ST_SRC;
			ST_SRC:    state_d = (mode_q == prc_pkg::MODE_GHOST) ? ST_SEARCH : ST_SCALE;
			ST_SCALE:  state_d = (cnt_q == 3'd4) ? ST_SEARCH : ST_SCALE;
			ST_SEARCH: state_d = (scan_q == AW'(PALETTE_ENTRIES - 1)) ? ST_DRAIN : ST_SEARCH;
			ST_DRAIN:  state_d = busy ? ST_DRAIN : ST_FINISH;
			ST_FINISH: state_d = out_load ? ST_IDLE : ST_FINISH;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= 3'd0;
			scan_q    <= AW'(1);
			out_vld_q <= 1'b0;
			shadow_q  <= prc_pkg::SHADOW_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCALE) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= 3'd0;
			end
			if (state_q == ST_SEARCH) begin
				scan_q <= scan_q + AW'(1);
			end else begin
				scan_q <= AW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_write) begin
				shadow_q <= cfg_wdata;
			end
		end
	end

	// Source entry, black when the index lies beyond the palette.
	assign src_val = src_ok_q ? rd_data : '0;

	// Request fields, target color and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.remap_mode;
			idx_q    <= req.color_index;
			level_q  <= req.fade_level;
			house_q  <= req.house_color;
			pos_q    <= 4'(idx_ext - 9'(HOUSE_RANGE_FIRST));
			src_ok_q <= src_ok_in;
			tgt_q    <= {req.red, req.green, req.blue};
			res_q    <= (req.remap_mode == prc_pkg::MODE_HOUSE ||
			             req.remap_mode > prc_pkg::MODE_GHOST) ? req.color_index : 8'd0;
		end
		if (state_q == ST_SRC) begin
			src_q <= src_val;
			tgt_q <= {ghost_of(src_val[RW-1 -: CW]), ghost_of(src_val[RW-1-CW -: CW]),
			          ghost_of(src_val[CW-1:0])};
		end
		if (state_q == ST_SCALE) begin
			case (cnt_q)
				3'd2:    tgt_q[RW-1 -: CW]    <= sc_result;
				3'd3:    tgt_q[RW-1-CW -: CW] <= sc_result;
				3'd4:    tgt_q[CW-1:0]        <= sc_result;
				default: tgt_q                <= tgt_q;
			endcase
		end
		if (state_q == ST_DRAIN) begin
			res_q <= 8'(near_idx);
		end
		if (out_load) begin
			out_idx_q <= res_q;
		end
	end

	// Operands for the shared scaling unit, one channel per cycle.
	assign shadow_clamp = (shadow_q > prc_pkg::SHADOW_FULL) ? prc_pkg::SHADOW_FULL : shadow_q;
	assign level_clamp  = (level_q > 4'(FADE_TOP)) ? 4'(FADE_TOP) : level_q;

	always_comb begin
		case (mode_q)
			prc_pkg::MODE_HOUSE: begin
				sc_kind    = prc_pkg::SCALE_HOUSE;
				sc_operand = chan_of(prc_pkg::house_base(house_q), cnt_q[1:0]);
				sc_factor  = prc_pkg::HOUSE_BIAS + 9'(pos_q) * prc_pkg::HOUSE_STEP;
			end
			prc_pkg::MODE_SHADOW: begin
				sc_kind    = prc_pkg::SCALE_SHADOW;
				sc_operand = chan_of(src_q, cnt_q[1:0]);
				sc_factor  = prc_pkg::SHADOW_FULL - shadow_clamp;
			end
			default: begin
				sc_kind    = prc_pkg::SCALE_FADE;
				sc_operand = chan_of(src_q, cnt_q[1:0]);
				sc_factor  = 9'(4'(FADE_TOP) - level_clamp);
			end
		endcase
	end

	// Palette port controls.
	always_comb begin
		ctl.wr_en = accept && !is_query && src_ok_in;
		ctl.rd_en = (state_q == ST_SRC_RD) || (state_q == ST_SEARCH);
		ctl.scan  = (state_q == ST_SEARCH);
		rd_addr   = (state_q == ST_SEARCH) ? scan_q : idx_q[AW-1:0];
	end

	prc_scale #(
		.FADE_STEPS (FADE_STEPS)
	) u_scale (
		.clk     (clk),
		.operand (sc_operand),
		.factor  (sc_factor),
		.kind    (sc_kind),
		.result  (sc_result)
	);

	prc_search #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_addr  (req.color_index[AW-1:0]),
		.wr_data  ({req.red, req.green, req.blue}),
		.rd_addr  (rd_addr),
		.target   (tgt_q),
		.rd_data  (rd_data),
		.busy     (busy),
		.near_idx (near_idx)
	);

	// Response channel.
	assign rsp.valid       = out_vld_q;
	assign rsp.match_index = out_idx_q;

endmodule

>>> hw/rtl/prc_scale.sv
`timescale 1ns / 1ps

// Shared two-stage scaling unit: result = operand * factor / divisor, where
// the divisor depends on the rule. The product and the result are registered.
module prc_scale #(
	parameter int FADE_STEPS = prc_pkg::FADE_STEPS
) (
	input  logic                            clk,
	input  logic [prc_pkg::CHAN_W-1:0]      operand,
	input  logic [prc_pkg::FACTOR_W-1:0]    factor,
	input  prc_pkg::scale_kind_t            kind,
	output logic [prc_pkg::CHAN_W-1:0]      result
);

	localparam int PROD_W    = prc_pkg::CHAN_W + prc_pkg::FACTOR_W;
	localparam int FULL_W    = PROD_W + prc_pkg::RECIP_W;
	localparam int FADE_TOP  = FADE_STEPS - 1;
	localparam logic [prc_pkg::RECIP_W-1:0] FADE_RECIP =
		prc_pkg::RECIP_W'(((1 << prc_pkg::RECIP_SHIFT) + FADE_TOP - 1) / FADE_TOP);

	logic [PROD_W-1:0]               prod_s1;
	prc_pkg::scale_kind_t            kind_s1;
	logic [prc_pkg::RECIP_W-1:0]     recip;
	logic [FULL_W-1:0]               full;
	logic [prc_pkg::CHAN_W-1:0]      result_s2;

	// First stage: channel times the shading factor.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(operand) * PROD_W'(factor);
		kind_s1 <= kind;
	end

	// Second stage: divide by multiplying with the reciprocal of the divisor.
	always_comb begin
		case (kind_s1)
			prc_pkg::SCALE_HOUSE:  recip = prc_pkg::HOUSE_RECIP;
			prc_pkg::SCALE_SHADOW: recip = prc_pkg::SHADOW_RECIP;
			default:               recip = FADE_RECIP;
		endcase
		full = FULL_W'(prod_s1) * FULL_W'(recip);
	end

	always_ff @(posedge clk) begin
		result_s2 <= full[prc_pkg::RECIP_SHIFT +: prc_pkg::CHAN_W];
	end

	assign result = result_s2;

endmodule

>>> hw/rtl/prc_search.sv
`timescale 1ns / 1ps

// Palette memory with a three-stage squared distance pipeline that keeps the
// nearest entry seen since the scan started.
module prc_search #(
	parameter  int PALETTE_ENTRIES = prc_pkg::PALETTE_ENTRIES,
	localparam int AW              = $clog2(PALETTE_ENTRIES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prc_pkg::mem_ctl_t             ctl,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [prc_pkg::RGB_W-1:0]     wr_data,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [prc_pkg::RGB_W-1:0]     target,
	output logic [prc_pkg::RGB_W-1:0]     rd_data,
	output logic                          busy,
	output logic [AW-1:0]                 near_idx
);

	localparam int CW = prc_pkg::CHAN_W;
	localparam int SW = 2 * prc_pkg::CHAN_W;

	logic [prc_pkg::RGB_W-1:0]  mem [PALETTE_ENTRIES];
	logic [prc_pkg::RGB_W-1:0]  rd_data_s1;
	logic [AW-1:0]              idx_s1;
	logic                       vld_s1;
	logic [SW-1:0]              sq_s2 [3];
	logic [AW-1:0]              idx_s2;
	logic                       vld_s2;
	logic [prc_pkg::DIST_W-1:0] best_d_q;
	logic [AW-1:0]              best_idx_q;

	logic [CW-1:0]              tch [3];
	logic [CW-1:0]              pch [3];
	logic [CW-1:0]              dif [3];
	logic [SW-1:0]              sq_d [3];
	logic [prc_pkg::DIST_W-1:0] sq_sum;
	logic                       clear;

	// Single write port and single registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		idx_s1 <= rd_addr;
	end

	// Per-channel absolute difference and square.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tch[k]  = target[prc_pkg::RGB_W-1-CW*k -: CW];
			pch[k]  = rd_data_s1[prc_pkg::RGB_W-1-CW*k -: CW];
			dif[k]  = (tch[k] > pch[k]) ? (tch[k] - pch[k]) : (pch[k] - tch[k]);
			sq_d[k] = SW'(dif[k]) * SW'(dif[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= sq_d[k];
		end
		idx_s2 <= idx_s1;
	end

	// Sum of squares, then keep the first strictly smaller distance.
	assign sq_sum = prc_pkg::DIST_W'(sq_s2[0]) + prc_pkg::DIST_W'(sq_s2[1])
	              + prc_pkg::DIST_W'(sq_s2[2]);
	assign clear  = ctl.scan && (rd_addr == AW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			best_d_q   <= '1;
			best_idx_q <= AW'(1);
		end else begin
			vld_s1 <= ctl.rd_en && ctl.scan;
			vld_s2 <= vld_s1;
			if (clear) begin
				best_d_q   <= '1;
				best_idx_q <= AW'(1);
			end else if (vld_s2 && (sq_sum < best_d_q)) begin
				best_d_q   <= sq_sum;
				best_idx_q <= idx_s2;
			end
		end
	end

	assign rd_data  = rd_data_s1;
	assign busy     = vld_s1 || vld_s2;
	assign near_idx = best_idx_q;

endmodule

>>> test/palette_remap_nearest_color_unit_tb.sv
`timescale 1ns / 1ps

module palette_remap_nearest_color_unit_tb;

	localparam int          RESET_CYCLES     = 11;
	localparam int          SETTLE_CYCLES    = prc_pkg::PALETTE_ENTRIES + 40;
	localparam int          RSP_HOLD_CYCLES  = 1500;
	localparam int          RANDOM_PER_PHASE = 200;
	localparam int          PHASE_COUNT      = 7;
	localparam int unsigned LIMIT_CYCLES     = 2_500_000;

	// Spare mode codes pass the source index straight through.
	localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;

	// Palette colors that set up tie and edge cases for the search.
	localparam logic [23:0] TWIN_RGB         = 24'h3C9A21;
	localparam logic [23:0] GREY_LOW_RGB     = 24'h646464;
	localparam logic [23:0] GREY_HIGH_RGB    = 24'h666464;
	localparam logic [23:0] LAST_ENTRY_RGB   = 24'h03FA4D;

	typedef struct {
		logic       req_type;
		logic [7:0] color_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] remap_mode;
		logic [3:0] fade_level;
		logic [2:0] house_color;
	} remap_request_t;

	// Mirrors the palette and the shadow setting, and holds the match indexes still owed.
	class remap_scoreboard;
		// House base colors, entry 0 in the low bits, each as {red, green, blue}.
		localparam logic [8*24-1:0] HOUSE_BASES = {
			24'h8C5028, 24'h0000FF, 24'h808080, 24'hFF8000,
			24'h00C800, 24'hFF0000, 24'h00A0FF, 24'hFFFF00
		};
		localparam int unsigned HOUSE_DIVISOR = 150;

		bit [23:0] palette_mirror [prc_pkg::PALETTE_ENTRIES];
		bit [8:0]  shadow_level;
		bit [7:0]  expected_matches [$];
		int        errors;

		function new();
			shadow_level = prc_pkg::SHADOW_RESET;
			errors = 0;
		endfunction

		function void set_shadow_level(bit [8:0] value);
			shadow_level = value;
		endfunction

		// Entry 0 is never a candidate. A later entry must be strictly closer to win.
		function bit [7:0] nearest_entry(bit [23:0] target);
			bit [7:0]    win_idx;
			int unsigned win_sum;
			int unsigned dist_sum;
			int          diff;
			win_idx = 8'd1;
			win_sum = 32'hFFFF_FFFF;
			for (int i = 1; i < prc_pkg::PALETTE_ENTRIES; i++) begin
				dist_sum = 0;
				for (int k = 0; k < 3; k++) begin
					diff = int'(target[8*k +: 8]) - int'(palette_mirror[i][8*k +: 8]);
					dist_sum += diff * diff;
				end
				if (dist_sum < win_sum) begin
					win_sum = dist_sum;
					win_idx = 8'(i);
				end
			end
			return win_idx;
		endfunction

		// House shade scales the base by (45 + 7*pos) / 150, clamped to full scale.
		function bit [23:0] house_target(bit [2:0] house, bit [7:0] idx);
			bit [23:0]   base;
			bit [23:0]   target;
			int unsigned factor;
			int unsigned v;
			base = HOUSE_BASES[house*24 +: 24];
			factor = int'(prc_pkg::HOUSE_BIAS) +
				int'(prc_pkg::HOUSE_STEP) * (int'(idx) - prc_pkg::HOUSE_RANGE_FIRST);
			for (int k = 0; k < 3; k++) begin
				v = int'(base[8*k +: 8]) * factor / HOUSE_DIVISOR;
				target[8*k +: 8] = (v > int'(prc_pkg::CHAN_MAX)) ? prc_pkg::CHAN_MAX : 8'(v);
			end
			return target;
		endfunction

		// One source channel under the shadow, fade or ghost rule.
		function bit [7:0] shade_channel(bit [2:0] mode, bit [7:0] s, bit [3:0] fade_step);
			int unsigned sv;
			int unsigned keep;
			int unsigned top;
			int unsigned step;
			sv = s;
			top = prc_pkg::FADE_STEPS - 1;
			case (mode)
				prc_pkg::MODE_SHADOW: begin
					keep = (shadow_level > prc_pkg::SHADOW_FULL) ? 0 :
						int'(prc_pkg::SHADOW_FULL) - int'(shadow_level);
					return 8'(sv * keep / int'(prc_pkg::SHADOW_FULL));
				end
				prc_pkg::MODE_FADE: begin
					step = (fade_step > top) ? top : fade_step;
					return 8'(sv * (top - step) / top);
				end
				default: begin
					return 8'(sv + (int'(prc_pkg::CHAN_MAX) - sv) / 2);
				end
			endcase
		endfunction

		// Writes update the mirror; queries queue the index the block must return.
		function void note_request(remap_request_t item);
			bit [23:0] source_rgb;
			bit [23:0] target;
			bit [7:0]  idx;
			idx = item.color_index;
			if (item.req_type == prc_pkg::REQ_WRITE) begin
				palette_mirror[idx] = {item.red, item.green, item.blue};
				return;
			end
			case (item.remap_mode) inside
				prc_pkg::MODE_DIRECT: begin
					expected_matches.push_back(nearest_entry({item.red, item.green, item.blue}));
				end
				prc_pkg::MODE_HOUSE: begin
					if (idx >= prc_pkg::HOUSE_RANGE_FIRST &&
					    idx < prc_pkg::HOUSE_RANGE_FIRST + prc_pkg::HOUSE_SHADES)
						expected_matches.push_back(nearest_entry(house_target(item.house_color, idx)));
					else
						expected_matches.push_back(idx);
				end
				prc_pkg::MODE_SHADOW, prc_pkg::MODE_FADE, prc_pkg::MODE_GHOST: begin
					if (idx == 8'd0) begin
						expected_matches.push_back(8'd0);
					end else begin
						source_rgb = palette_mirror[idx];
						for (int k = 0; k < 3; k++)
							target[8*k +: 8] = shade_channel(item.remap_mode, source_rgb[8*k +: 8],
								item.fade_level);
						expected_matches.push_back(nearest_entry(target));
					end
				end
				default: begin
					expected_matches.push_back(idx);
				end
			endcase
		endfunction

		function void check_result(logic [7:0] got);
			bit [7:0] want;
			if (expected_matches.size() == 0) begin
				errors++;
				$display("%0t: match_index expected none, got %0d", $time, got);
				return;
			end
			want = expected_matches.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: match_index expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function void check_drained();
			while (expected_matches.size() != 0) begin
				errors++;
				$display("%0t: match_index expected %0d, got none", $time,
					expected_matches.pop_front());
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [8:0]  cfg_wdata;
	bit          idling = 1'b1;
	bit          hold_responses = 1'b0;
	int unsigned cycle_count = 0;
	bit [8:0]    shadow_plan [PHASE_COUNT];

	remap_scoreboard sb = new();

	prc_req_if req_bus();
	prc_rsp_if rsp_bus();

	palette_remap_nearest_color_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_write (cfg_write),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("palette_remap_nearest_color_unit regression: fail");
			$finish;
		end
	end

	// Every response taken by the receiver is checked against the oldest query.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			sb.check_result(rsp_bus.match_index);
	end

	// Receiver: random stall bursts while idling is set, plus one long hold-off on request.
	initial begin
		int stall;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_responses) begin
				rsp_bus.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
				hold_responses = 1'b0;
			end else if (idling && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(1, 19);
				rsp_bus.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	function automatic remap_request_t make_request(logic kind, logic [7:0] idx,
			logic [23:0] rgb, logic [2:0] mode, logic [3:0] fade_step, logic [2:0] house);
		remap_request_t item;
		item.req_type = kind;
		item.color_index = idx;
		{item.red, item.green, item.blue} = rgb;
		item.remap_mode = mode;
		item.fade_level = fade_step;
		item.house_color = house;
		return item;
	endfunction

	// Mostly queries over the loaded palette, with writes that keep reshaping it.
	function automatic remap_request_t random_request();
		remap_request_t item;
		int unsigned    roll;
		int unsigned    pick;
		item.color_index = 8'($urandom);
		item.red = 8'($urandom);
		item.green = 8'($urandom);
		item.blue = 8'($urandom);
		item.remap_mode = 3'($urandom);
		item.fade_level = 4'($urandom);
		item.house_color = 3'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			item.req_type = prc_pkg::REQ_WRITE;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// Duplicate an existing color so the search meets ties.
				{item.red, item.green, item.blue} =
					sb.palette_mirror[$urandom_range(1, prc_pkg::PALETTE_ENTRIES - 1)];
			end else if (pick == 1) begin
				item.red = $urandom_range(0, 1) ? prc_pkg::CHAN_MAX : 8'd0;
				item.green = $urandom_range(0, 1) ? prc_pkg::CHAN_MAX : 8'd0;
				item.blue = $urandom_range(0, 1) ? prc_pkg::CHAN_MAX : 8'd0;
			end
			return item;
		end
		item.req_type = prc_pkg::REQ_QUERY;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			item.remap_mode = prc_pkg::MODE_DIRECT;
		end else if (pick < 45) begin
			item.remap_mode = prc_pkg::MODE_HOUSE;
			if ($urandom_range(0, 3) != 0)
				item.color_index = 8'(prc_pkg::HOUSE_RANGE_FIRST +
					$urandom_range(0, prc_pkg::HOUSE_SHADES - 1));
		end else if (pick < 92) begin
			item.remap_mode = (pick < 60) ? prc_pkg::MODE_SHADOW :
				(pick < 75) ? prc_pkg::MODE_FADE : prc_pkg::MODE_GHOST;
			if ($urandom_range(0, 19) == 0)
				item.color_index = 8'd0;
		end else begin
			item.remap_mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
		end
		return item;
	endfunction

	// Offer one request, wait for it to be taken, then maybe leave a gap.
	task automatic send_request(input remap_request_t item);
		int gap;
		req_bus.valid <= 1'b1;
		req_bus.req_type <= item.req_type;
		req_bus.color_index <= item.color_index;
		req_bus.red <= item.red;
		req_bus.green <= item.green;
		req_bus.blue <= item.blue;
		req_bus.remap_mode <= item.remap_mode;
		req_bus.fade_level <= item.fade_level;
		req_bus.house_color <= item.house_color;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		sb.note_request(item);
		@(negedge clk);
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Offer one query request with the given fields.
	task automatic send_query(input logic [7:0] idx, input logic [23:0] rgb,
			input logic [2:0] mode, input logic [3:0] fade_step, input logic [2:0] house);
		send_request(make_request(prc_pkg::REQ_QUERY, idx, rgb, mode, fade_step, house));
	endtask

	// Stop offering, wait for every owed response, then let the block go quiet.
	task automatic drain_and_settle();
		req_bus.valid <= 1'b0;
		while (sb.expected_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_shadow_level(input bit [8:0] value);
		cfg_wdata <= value;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.set_shadow_level(value);
	endtask

	initial begin
		logic [23:0] rgb;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_wdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= prc_pkg::REQ_WRITE;
		req_bus.color_index <= '0;
		req_bus.red <= '0;
		req_bus.green <= '0;
		req_bus.blue <= '0;
		req_bus.remap_mode <= prc_pkg::MODE_DIRECT;
		req_bus.fade_level <= '0;
		req_bus.house_color <= '0;
		shadow_plan[0] = 9'd0;
		shadow_plan[1] = prc_pkg::SHADOW_FULL;
		shadow_plan[2] = 9'h1FF;
		shadow_plan[3] = 9'($urandom_range(1, 255));
		shadow_plan[4] = 9'd300;
		shadow_plan[5] = 9'd64;
		shadow_plan[6] = prc_pkg::SHADOW_RESET;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Load every entry before any query; a few entries are fixed for tie and edge cases.
		for (int i = 0; i < prc_pkg::PALETTE_ENTRIES; i++) begin
			case (i)
				1:       rgb = 24'h000000;
				2:       rgb = 24'hFFFFFF;
				10, 11:  rgb = TWIN_RGB;
				20:      rgb = GREY_LOW_RGB;
				21:      rgb = GREY_HIGH_RGB;
				default: rgb = 24'($urandom);
			endcase
			send_request(make_request(prc_pkg::REQ_WRITE, 8'(i), rgb, prc_pkg::MODE_DIRECT,
				4'd0, 3'd0));
		end

		// Directed queries at the reset shadow setting.
		send_query(8'd0, 24'h000000, prc_pkg::MODE_DIRECT, 4'd0, 3'd0);
		send_query(8'd255, 24'hFFFFFF, prc_pkg::MODE_DIRECT, 4'd15, 3'd7);
		send_query(8'd7, 24'h656464, prc_pkg::MODE_DIRECT, 4'd0, 3'd0);
		send_query(8'd9, TWIN_RGB, prc_pkg::MODE_DIRECT, 4'd0, 3'd0);
		send_query(8'd80, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd0);
		send_query(8'd87, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd1);
		send_query(8'd95, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd7);
		send_query(8'd79, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd2);
		send_query(8'd96, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd4);
		send_query(8'd0, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd6);
		send_query(8'd90, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd5);
		send_query(8'd84, 24'h000000, prc_pkg::MODE_HOUSE, 4'd0, 3'd3);
		send_query(8'd0, 24'hFFFFFF, prc_pkg::MODE_SHADOW, 4'd0, 3'd0);
		send_query(8'd2, 24'h000000, prc_pkg::MODE_SHADOW, 4'd0, 3'd0);
		send_query(8'd255, 24'h000000, prc_pkg::MODE_SHADOW, 4'd0, 3'd0);
		send_query(8'd2, 24'h000000, prc_pkg::MODE_FADE, 4'd0, 3'd0);
		send_query(8'd2, 24'h000000, prc_pkg::MODE_FADE, 4'd15, 3'd0);
		send_query(8'd0, 24'h000000, prc_pkg::MODE_FADE, 4'd9, 3'd0);
		send_query(8'd1, 24'h000000, prc_pkg::MODE_GHOST, 4'd0, 3'd0);
		send_query(8'd0, 24'h000000, prc_pkg::MODE_GHOST, 4'd0, 3'd0);
		send_query(8'd2, 24'h000000, prc_pkg::MODE_GHOST, 4'd0, 3'd0);
		send_query(8'd123, 24'h000000, MODE_SPARE_FIRST, 4'd0, 3'd0);
		send_query(8'd0, 24'hFFFFFF, 3'(MODE_SPARE_FIRST + 1), 4'd0, 3'd0);
		send_query(8'd255, 24'h000000, MODE_SPARE_LAST, 4'd0, 3'd0);
		send_request(make_request(prc_pkg::REQ_WRITE, 8'd255, LAST_ENTRY_RGB,
			prc_pkg::MODE_DIRECT, 4'd0, 3'd0));
		send_query(8'd0, LAST_ENTRY_RGB, prc_pkg::MODE_DIRECT, 4'd0, 3'd0);

		// Random phases, each under its own shadow setting, written while the block is quiet.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_and_settle();
			write_shadow_level(shadow_plan[p]);
			if (p == 2)
				hold_responses = 1'b1;
			if (p == PHASE_COUNT - 1)
				idling = 1'b0;
			repeat (RANDOM_PER_PHASE) send_request(random_request());
		end
		drain_and_settle();
		sb.check_drained();

		if (sb.errors == 0)
			$display("palette_remap_nearest_color_unit regression: pass");
		else
			$display("palette_remap_nearest_color_unit regression: fail");
		$finish;
	end

endmodule

>>> palette_remap_nearest_color_unit.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_req_if.sv
hw/rtl/prc_rsp_if.sv
hw/rtl/prc_scale.sv
hw/rtl/prc_search.sv
hw/rtl/palette_remap_nearest_color_unit.sv
test/palette_remap_nearest_color_unit_tb.sv
